FILE: rtl/bb7_pkg.sv
// Shared constants, types and helper functions for the 7x7 clipped box blur.
// Depends on nothing; every other file in rtl/ imports it.
`default_nettype none

package bb7_pkg;

	localparam int IMAGE_SIDE = 256;
	localparam int RADIUS     = 3;
	localparam int WIN        = 2 * RADIUS + 1;
	localparam int ROWS_KEPT  = WIN;
	localparam int LS_DEPTH   = ROWS_KEPT * IMAGE_SIDE;

	localparam int ADDR_W   = $clog2(LS_DEPTH);
	localparam int COL_W    = $clog2(IMAGE_SIDE);
	localparam int ROW_W    = $clog2(IMAGE_SIDE + 1);
	localparam int OFS_W    = $clog2(IMAGE_SIDE + WIN);
	localparam int BANK_W   = $clog2(ROWS_KEPT);
	localparam int K_W      = $clog2(WIN);
	localparam int PIX_W    = 8;
	localparam int COLSUM_W = 11;
	localparam int SUM_W    = 14;
	localparam int RECIP_W  = 17;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam int DIV_SHIFT = 20;

	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [BANK_W-1:0] bank_t;
	typedef logic [OFS_W-1:0]  ofs_t;

	// line store write port
	typedef struct packed {
		logic              en;
		bank_t             bank;
		col_t              col;
		logic [PIX_W-1:0]  data;
	} ls_wr_t;

	// column sum request: center row/column of the column to add up
	typedef struct packed {
		logic  start;
		bank_t bank;
		col_t  col;
		row_t  row;
	} cs_req_t;

	typedef struct packed {
		logic                done;
		logic [COLSUM_W-1:0] sum;
	} cs_rsp_t;

	typedef struct packed {
		logic                start;
		logic                out_en;
		logic [COLSUM_W-1:0] colsum;
		col_t                orow;
		col_t                ocol;
	} mean_req_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] value;
	} mean_rsp_t;

	function automatic logic [ADDR_W-1:0] ls_addr(input bank_t bank, input col_t col);
		return ADDR_W'(int'(bank) * IMAGE_SIDE + int'(col));
	endfunction

	function automatic bank_t bank_inc(input bank_t b);
		return (b == BANK_W'(ROWS_KEPT - 1)) ? '0 : b + BANK_W'(1);
	endfunction

	// offset coordinate (true coordinate plus RADIUS) lies inside the image
	function automatic logic in_image(input ofs_t v);
		return (v >= OFS_W'(RADIUS)) && (v <= OFS_W'(IMAGE_SIDE - 1 + RADIUS));
	endfunction

	// ceil(2^DIV_SHIFT / count) for count = (4 + rows_idx) * (4 + cols_idx)
	function automatic logic [RECIP_W-1:0] recip(input logic [1:0] r_idx,
			input logic [1:0] c_idx);
		logic [RECIP_W-1:0] m;
		case ({r_idx, c_idx})
			4'b0000:          m = RECIP_W'(65536);
			4'b0001, 4'b0100: m = RECIP_W'(52429);
			4'b0010, 4'b1000: m = RECIP_W'(43691);
			4'b0011, 4'b1100: m = RECIP_W'(37450);
			4'b0101:          m = RECIP_W'(41944);
			4'b0110, 4'b1001: m = RECIP_W'(34953);
			4'b0111, 4'b1101: m = RECIP_W'(29960);
			4'b1010:          m = RECIP_W'(29128);
			4'b1011, 4'b1110: m = RECIP_W'(24967);
			4'b1111:          m = RECIP_W'(21400);
			default:          m = RECIP_W'(21400);
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/box_blur_7x7_clipped.sv
// 7x7 box blur with border clipping over a square 8-bit grayscale image.
// Send IMAGE_SIDE*IMAGE_SIDE pixel words (mode 0) in raster order on the
// pix channel, then 3*IMAGE_SIDE+3 flush words (mode 1). Each blurred word
// leaves on the res channel in raster order; frame_end marks the last one.
// A flush word before the frame is complete is dropped; a pixel word after
// the frame is complete counts as a flush. After the last result all
// counters clear and the next pixel word starts a new frame.
// Timing: a word of the first three rows is taken with no stall. A word that
// fetches a column but gives no result holds pix_stall high until the column
// sum is done; a word that gives a result also waits for the mean pipeline
// and the push into the output register before the next word is taken. The
// seven reads of the line store per column and the mean pipeline set this pace.
// One result word is held in the output register; while res_stall holds it,
// the block carries its current word up to the push and holds pix_stall high.
// Reset clears all counters and the output valid; the line store is not
// cleared, since an entry read before it is written in a frame is masked.
// Depends on bb7_pkg, bb7_colsum and bb7_mean.
`default_nettype none

module box_blur_7x7_clipped import bb7_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pix_valid,
	output logic                  pix_stall,
	input  wire logic             mode,
	input  wire logic [PIX_W-1:0] pixel_in,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output logic [PIX_W-1:0]      blurred_pixel,
	output logic                  frame_end
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_MEAN  = 2'd2;
	localparam logic [1:0] ST_PUSH  = 2'd3;

	localparam bank_t QBANK_INIT = BANK_W'(ROWS_KEPT - RADIUS);

	logic [1:0]       state_q;
	row_t             in_row_q;
	col_t             in_col_q;
	bank_t            in_bank_q;
	row_t             q_row_q;
	col_t             q_col_q;
	bank_t            q_bank_q;
	col_t             o_row_q;
	col_t             o_col_q;
	logic             fetch_out_q;
	logic [PIX_W-1:0] res_q;
	logic             res_valid_q;
	logic [PIX_W-1:0] blurred_pixel_q;
	logic             frame_end_q;

	logic      pix_acc;
	logic      frame_open;
	logic      take_pixel;
	logic      fetch_go;
	logic      q_out;
	logic      out_free;
	logic      push;
	logic      last_px;
	ls_wr_t    ls_wr;
	cs_req_t   cs_req;
	cs_rsp_t   cs_rsp;
	mean_req_t mean_req;
	mean_rsp_t mean_rsp;

	assign pix_stall  = (state_q != ST_IDLE);
	assign pix_acc    = pix_valid && !pix_stall;
	assign frame_open = (in_row_q != ROW_W'(IMAGE_SIDE));
	assign take_pixel = pix_acc && frame_open && !mode;
	assign fetch_go   = pix_acc && (!frame_open || (!mode && in_row_q >= ROW_W'(RADIUS)));
	assign q_out      = (q_row_q != '0) || (q_col_q >= COL_W'(RADIUS));
	assign out_free   = !res_valid_q || !res_stall;
	assign push       = (state_q == ST_PUSH) && out_free;
	assign last_px    = (o_row_q == COL_W'(IMAGE_SIDE - 1)) && (o_col_q == COL_W'(IMAGE_SIDE - 1));

	assign ls_wr.en   = take_pixel;
	assign ls_wr.bank = in_bank_q;
	assign ls_wr.col  = in_col_q;
	assign ls_wr.data = pixel_in;

	assign cs_req.start = fetch_go;
	assign cs_req.bank  = q_bank_q;
	assign cs_req.col   = q_col_q;
	assign cs_req.row   = q_row_q;

	assign mean_req.start  = (state_q == ST_FETCH) && cs_rsp.done;
	assign mean_req.out_en = fetch_out_q;
	assign mean_req.colsum = cs_rsp.sum;
	assign mean_req.orow   = o_row_q;
	assign mean_req.ocol   = o_col_q;

	bb7_colsum u_colsum (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (ls_wr),
		.req    (cs_req),
		.rsp    (cs_rsp)
	);

	bb7_mean u_mean (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mean_req),
		.rsp    (mean_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (fetch_go) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (cs_rsp.done) begin
						state_q <= fetch_out_q ? ST_MEAN : ST_IDLE;
					end
				end
				ST_MEAN: begin
					if (mean_rsp.done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_bank_q   <= '0;
			q_row_q     <= '0;
			q_col_q     <= '0;
			q_bank_q    <= QBANK_INIT;
			o_row_q     <= '0;
			o_col_q     <= '0;
			fetch_out_q <= 1'b0;
		end else if (push && last_px) begin
			// frame drained: start over
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_bank_q   <= '0;
			q_row_q     <= '0;
			q_col_q     <= '0;
			q_bank_q    <= QBANK_INIT;
			o_row_q     <= '0;
			o_col_q     <= '0;
		end else begin
			if (take_pixel) begin
				if (in_col_q == COL_W'(IMAGE_SIDE - 1)) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + ROW_W'(1);
					in_bank_q <= bank_inc(in_bank_q);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (fetch_go) begin
				fetch_out_q <= q_out;
				if (q_col_q == COL_W'(IMAGE_SIDE - 1)) begin
					q_col_q  <= '0;
					q_row_q  <= q_row_q + ROW_W'(1);
					q_bank_q <= bank_inc(q_bank_q);
				end else begin
					q_col_q <= q_col_q + COL_W'(1);
				end
			end
			if (push) begin
				if (o_col_q == COL_W'(IMAGE_SIDE - 1)) begin
					o_col_q <= '0;
					o_row_q <= o_row_q + COL_W'(1);
				end else begin
					o_col_q <= o_col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MEAN && mean_rsp.done) begin
			res_q <= mean_rsp.value;
		end
		if (push) begin
			blurred_pixel_q <= res_q;
			frame_end_q     <= last_px;
		end
	end

	assign res_valid     = res_valid_q;
	assign blurred_pixel = blurred_pixel_q;
	assign frame_end     = frame_end_q;

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH) && !out_free |=> (state_q == ST_PUSH) && res_valid_q)
		else $error("result dropped while output word stalled");

	a_last_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		push && last_px |-> (q_row_q == ROW_W'(IMAGE_SIDE)) && (q_col_q == COL_W'(RADIUS))
			&& !frame_open)
		else $error("last output does not line up with fetch and input counters");

	a_mean_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		mean_rsp.done |-> (state_q == ST_MEAN))
		else $error("mean result outside its wait state");

	a_colsum_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		cs_rsp.done |-> (state_q == ST_FETCH))
		else $error("column sum outside its wait state");

endmodule

`default_nettype wire

FILE: rtl/bb7_colsum.sv
// Line store memory (seven image rows) and the sequencer that adds up one
// clipped seven-row column from it, one read per cycle. Uses bb7_pkg.
`default_nettype none

module bb7_colsum import bb7_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire ls_wr_t  wr,
	input  wire cs_req_t req,
	output cs_rsp_t      rsp
);

	logic [PIX_W-1:0] line_store_q [LS_DEPTH];

	logic                busy_q;
	logic [K_W-1:0]      k_q;
	bank_t               bank_q;
	col_t                col_q;
	ofs_t                rr_q;
	logic                rd_en_s1;
	logic                last_s1;
	logic                row_ok_s1;
	logic [PIX_W-1:0]    rd_data_s1;
	logic [COLSUM_W-1:0] acc_q;
	logic                done_q;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]   rd_addr;
	logic [COLSUM_W-1:0] term;

	assign wr_addr = ls_addr(wr.bank, wr.col);
	assign rd_addr = ls_addr(bank_q, col_q);
	assign term    = row_ok_s1 ? COLSUM_W'(rd_data_s1) : '0;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			line_store_q[wr_addr] <= wr.data;
		end
		if (busy_q) begin
			rd_data_s1 <= line_store_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			k_q       <= '0;
			rd_en_s1  <= 1'b0;
			last_s1   <= 1'b0;
			row_ok_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			rd_en_s1 <= busy_q;
			last_s1  <= busy_q && (k_q == K_W'(WIN - 1));
			row_ok_s1 <= in_image(rr_q);
			done_q   <= rd_en_s1 && last_s1;
			if (req.start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + K_W'(1);
				if (k_q == K_W'(WIN - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// walk rows center-3 .. center+3 of the requested column
	always_ff @(posedge clk) begin
		if (req.start) begin
			bank_q <= req.bank;
			col_q  <= req.col;
			rr_q   <= OFS_W'(req.row);
			acc_q  <= '0;
		end else begin
			if (busy_q) begin
				bank_q <= bank_inc(bank_q);
				rr_q   <= rr_q + OFS_W'(1);
			end
			if (rd_en_s1) begin
				acc_q <= acc_q + term;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.sum  = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q && !rd_en_s1)
		else $error("column fetch started while one is in flight");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q && (k_q == '0))
		else $error("column fetch did not begin at the first row");

	a_done_after_reads: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && !rd_en_s1)
		else $error("column sum reported before all reads returned");

endmodule

`default_nettype wire

FILE: rtl/bb7_mean.sv
// Seven-column window of column sums, clipped window sum and the divide by
// the in-image neighbor count through a reciprocal multiply. Uses bb7_pkg.
`default_nettype none

module bb7_mean import bb7_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire mean_req_t req,
	output mean_rsp_t      rsp
);

	logic [COLSUM_W-1:0] win_q [WIN];
	logic [WIN-1:0]      colmask_s1;
	logic [WIN-1:0]      rowmask_s1;
	logic                v_s1;
	logic                v_s2;
	logic                v_s3;
	logic [SUM_W-1:0]    sum_s2;
	logic [RECIP_W-1:0]  recip_s2;
	logic [PROD_W-1:0]   prod_s3;
	logic [WIN-1:0]      colmask_c;
	logic [WIN-1:0]      rowmask_c;
	logic [SUM_W-1:0]    sum_c;
	logic [2:0]          rcnt;
	logic [2:0]          ccnt;
	logic [2:0]          ridx;
	logic [2:0]          cidx;

	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			colmask_c[k] = in_image(OFS_W'(req.ocol) + OFS_W'(k));
			rowmask_c[k] = in_image(OFS_W'(req.orow) + OFS_W'(k));
		end
	end

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < WIN; k++) begin
			if (colmask_s1[k]) begin
				sum_c = sum_c + SUM_W'(win_q[k]);
			end
		end
	end

	assign rcnt = 3'($countones(rowmask_s1));
	assign ccnt = 3'($countones(colmask_s1));
	assign ridx = rcnt - 3'(RADIUS + 1);
	assign cidx = ccnt - 3'(RADIUS + 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.start && req.out_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// shift in the newest column on every fetch, output or not
	always_ff @(posedge clk) begin
		if (req.start) begin
			for (int k = 0; k < WIN - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[WIN-1] <= req.colsum;
			colmask_s1   <= colmask_c;
			rowmask_s1   <= rowmask_c;
		end
		sum_s2   <= sum_c;
		recip_s2 <= recip(ridx[1:0], cidx[1:0]);
		prod_s3  <= PROD_W'(sum_s2) * PROD_W'(recip_s2);
	end

	assign rsp.done  = v_s3;
	assign rsp.value = prod_s3[DIV_SHIFT +: PIX_W];

endmodule

`default_nettype wire

FILE: bench/box_blur_checker.sv
`timescale 1ns / 100ps
// Checker for the 7x7 clipped box blur: watches the pix and res channels,
// predicts every blurred word from the accepted pixel words, compares in order.
// Depends on bb7_pkg for the image size, window radius and widths.
module box_blur_checker import bb7_pkg::*; #(
	parameter logic FLUSH_CODE = 1'b1,
	parameter int   LAG        = RADIUS * IMAGE_SIDE + RADIUS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pix_valid,
	input  wire logic             pix_stall,
	input  wire logic             mode,
	input  wire logic [PIX_W-1:0] pixel_in,
	input  wire logic             res_valid,
	input  wire logic             res_stall,
	input  wire logic [PIX_W-1:0] blurred_pixel,
	input  wire logic             frame_end,
	output int                    fail_count,
	output int                    pending
);

	localparam int FRAME_PIXELS = IMAGE_SIDE * IMAGE_SIDE;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             last;
	} blurred_t;

	logic [PIX_W-1:0] kept_rows [ROWS_KEPT][IMAGE_SIDE];
	row_t             next_row  = '0;
	col_t             next_col  = '0;
	logic [16:0]      out_count = '0;
	blurred_t         blurred_q[$];
	blurred_t         want;

	function automatic logic [PIX_W-1:0] window_mean(input int pos);
		int r, c, rr, cc, sum, cnt;
		r = pos / IMAGE_SIDE;
		c = pos % IMAGE_SIDE;
		sum = 0;
		cnt = 0;
		for (rr = r - RADIUS; rr <= r + RADIUS; rr++)
			for (cc = c - RADIUS; cc <= c + RADIUS; cc++)
				if (rr >= 0 && rr < IMAGE_SIDE && cc >= 0 && cc < IMAGE_SIDE) begin
					sum += kept_rows[rr % ROWS_KEPT][cc];
					cnt++;
				end
		return PIX_W'(sum / cnt);
	endfunction

	task automatic predict_blur(input logic m, input logic [PIX_W-1:0] p);
		int n;
		if (int'(next_row) < IMAGE_SIDE) begin
			// drop a flush word while the frame is still coming in
			if (m == FLUSH_CODE)
				return;
			kept_rows[int'(next_row) % ROWS_KEPT][next_col] = p;
			n = int'(next_row) * IMAGE_SIDE + int'(next_col);
			if (next_col == col_t'(IMAGE_SIDE - 1)) begin
				next_col = '0;
				next_row++;
			end else begin
				next_col++;
			end
			if (n < LAG)
				return;
		end
		// a pixel word past the lag, or any word once the frame is complete, drains one result
		blurred_q.push_back('{value: window_mean(int'(out_count)),
			last: (int'(out_count) == FRAME_PIXELS - 1)});
		out_count++;
		if (int'(out_count) >= FRAME_PIXELS) begin
			next_row = '0;
			next_col = '0;
			out_count = '0;
		end
	endtask

	task automatic note_failure(input string what, input int expected, input int actual);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what,
			expected, actual);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_row = '0;
			next_col = '0;
			out_count = '0;
			blurred_q.delete();
			pending = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (blurred_q.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual blurred_pixel %0d frame_end %0d",
						$time, blurred_pixel, frame_end);
					fail_count++;
				end else begin
					want = blurred_q.pop_front();
					if (blurred_pixel !== want.value)
						note_failure("blurred_pixel", want.value, blurred_pixel);
					if (frame_end !== want.last)
						note_failure("frame_end", want.last, frame_end);
				end
			end
			if (pix_valid && !pix_stall)
				predict_blur(mode, pixel_in);
			pending = blurred_q.size();
		end
	end

endmodule

FILE: bench/box_blur_7x7_clipped_test.sv
`timescale 1ns / 100ps
// Top of the box blur bench: clock, reset, pixel and flush stimulus with random
// gaps and result stalls, and the verdict. Depends on bb7_pkg, the block and
// box_blur_checker, which does all prediction and comparison.
module box_blur_7x7_clipped_test;
	import bb7_pkg::*;

	localparam logic MODE_PIXEL  = 1'b0;
	localparam logic MODE_FLUSH  = 1'b1;
	localparam int   DRAIN_WORDS = RADIUS * IMAGE_SIDE + RADIUS;
	localparam int   PIXEL_WORDS = 1680;
	localparam int   PAUSE_AT    = 1200;
	localparam int   SETTLE      = 24;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             pix_valid = 1'b0;
	logic             mode = MODE_PIXEL;
	logic [PIX_W-1:0] pixel_in = '0;
	logic             res_stall = 1'b0;
	logic             pix_stall;
	logic             res_valid;
	logic [PIX_W-1:0] blurred_pixel;
	logic             frame_end;
	int               fail_count;
	int               pending;
	bit               quiet = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	box_blur_7x7_clipped uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.mode          (mode),
		.pixel_in      (pixel_in),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.blurred_pixel (blurred_pixel),
		.frame_end     (frame_end)
	);

	box_blur_checker #(
		.FLUSH_CODE (MODE_FLUSH),
		.LAG        (DRAIN_WORDS)
	) blur_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.mode          (mode),
		.pixel_in      (pixel_in),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.blurred_pixel (blurred_pixel),
		.frame_end     (frame_end),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// mostly none or short, now and then long; none at all in a quiet stretch
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 97)
			return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	function automatic logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// full-scale band at the left edge, a dark band beside it, a checkerboard row
	function automatic logic [PIX_W-1:0] frame_pixel(input int row, input int col);
		if (col < 16)
			return '1;
		if (col < 32)
			return '0;
		if (row == 5)
			return ((row + col) % 2 != 0) ? '1 : '0;
		return random_pixel();
	endfunction

	task automatic send_word(input logic m, input logic [PIX_W-1:0] p);
		int gap;
		mode <= m;
		pixel_in <= p;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender until every predicted word has come out
	task automatic hold_until_drained();
		pix_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int run;
		forever begin
			@(posedge clk);
			res_stall <= 1'b0;
			run = quiet ? 16 : $urandom_range(4, 20);
			repeat (run) @(posedge clk);
			run = pick_gap();
			if (run > 0) begin
				res_stall <= 1'b1;
				repeat (run - 1) @(posedge clk);
			end
		end
	end

	initial begin
		int i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flush words with no frame under way are dropped
		send_word(MODE_FLUSH, '1);
		send_word(MODE_FLUSH, '0);
		send_word(MODE_FLUSH, 8'h5A);

		// flush words mixed into the frame are dropped as well
		for (i = 0; i < PIXEL_WORDS; i++) begin
			if (i % IMAGE_SIDE == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (i == PAUSE_AT)
				hold_until_drained();
			if ($urandom_range(0, 99) == 0)
				send_word(MODE_FLUSH, random_pixel());
			send_word(MODE_PIXEL, frame_pixel(i / IMAGE_SIDE, i % IMAGE_SIDE));
		end

		hold_until_drained();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// 20 ms: several times the slowest legal run of about 1700 words
	initial begin
		#(20_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule
